FILE: design/jpd_pkg.sv
// ----------------------------------------------------------------------------
// jpd_pkg: shared types and constants for the joystick polar direction block
// Holds the payload structs, the register map, the fixed-point constants,
// the CORDIC arctangent table and the compass sector edges.
// ----------------------------------------------------------------------------
package jpd_pkg;

  // Width of one ADC conversion result.
  localparam int unsigned ADC_BITS = 12;

  // Default number of CORDIC micro-rotations.
  localparam int unsigned CORDIC_STEPS_DEF = 16;

  // Q2.14 unity.
  localparam int unsigned Q14_ONE = 16384;

  // Angle units: the CORDIC accumulates in 1/16384 degree.
  localparam int unsigned HALF_TURN_FINE = 180 * 16384;
  localparam int unsigned FULL_TURN_FINE = 360 * 16384;
  // Heading output is in 1/64 degree.
  localparam int unsigned FULL_TURN_64   = 23040;

  // CORDIC datapath widths.
  localparam int unsigned CORDIC_CW = 26;
  localparam int unsigned CORDIC_ZW = 25;

  // Register map (index of each 32-bit register).
  localparam logic [1:0] REG_X_CENTRE  = 2'd0;
  localparam logic [1:0] REG_Y_CENTRE  = 2'd1;
  localparam logic [1:0] REG_DEAD_ZONE = 2'd2;

  localparam logic [ADC_BITS-1:0] X_CENTRE_RST  = ADC_BITS'(2048);
  localparam logic [ADC_BITS-1:0] Y_CENTRE_RST  = ADC_BITS'(2048);
  localparam logic [14:0]         DEAD_ZONE_RST = 15'd1638;

  // Direction codes.
  localparam logic [3:0] DIR_CENTRE = 4'd0;
  localparam logic [3:0] DIR_N      = 4'd1;

  // arctan(2^-i) in 1/16384 degree.
  localparam logic [19:0] ATAN_FINE [24] = '{
    20'd737280, 20'd435242, 20'd229970, 20'd116736, 20'd58595, 20'd29326,
    20'd14667,  20'd7334,   20'd3667,   20'd1833,   20'd917,   20'd458,
    20'd229,    20'd115,    20'd57,     20'd29,     20'd14,    20'd7,
    20'd4,      20'd2,      20'd1,      20'd0,      20'd0,     20'd0
  };

  // Sector edges in 1/64 degree: 22.5, 67.5, ... 337.5 degrees.
  localparam logic [14:0] SECTOR_EDGE [8] = '{
    15'd1440, 15'd4320, 15'd7200, 15'd10080,
    15'd12960, 15'd15840, 15'd18720, 15'd21600
  };

  // One input transaction.
  typedef struct packed {
    logic [ADC_BITS-1:0] horiz_sample;
    logic [ADC_BITS-1:0] vert_sample;
  } in_t;

  // One result transaction.
  typedef struct packed {
    logic [3:0]         direction;
    logic [14:0]        magnitude;
    logic [14:0]        heading;
    logic               heading_valid;
    logic signed [15:0] mapped_x;
    logic signed [15:0] mapped_y;
  } out_t;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [ADC_BITS-1:0] x_centre;
    logic [ADC_BITS-1:0] y_centre;
    logic [14:0]         dead_zone;
  } cfg_t;

  // Scale a centred ADC difference to Q2.14, truncating toward zero and
  // saturating at plus or minus one.
  function automatic logic signed [15:0] scale_axis(input logic signed [ADC_BITS:0] d);
    logic [ADC_BITS-1:0]    mag;
    logic [ADC_BITS+14:0]   wide;
    logic [14:0]            sat;
    mag  = d[ADC_BITS] ? ADC_BITS'(-d) : ADC_BITS'(d);
    wide = {mag, 15'd0} >> ADC_BITS;
    sat  = (wide > (ADC_BITS+15)'(Q14_ONE)) ? 15'(Q14_ONE) : wide[14:0];
    return d[ADC_BITS] ? -$signed({1'b0, sat}) : $signed({1'b0, sat});
  endfunction

endpackage

FILE: design/joystick_polar_direction.sv
// ----------------------------------------------------------------------------
// joystick_polar_direction: joystick sample pair to polar form and direction
// Centres and scales a pair of ADC samples, maps the square onto the unit
// circle, and reports magnitude, compass heading and an eight-way direction.
// ----------------------------------------------------------------------------
// The block accepts one sample pair per clock while the output is not
// stalled and returns one result per pair, in order. A pair passes through
// two 15-stage square-root pipelines in turn, one CORDIC stage per
// micro-rotation, and the scaling, multiply, rounding and output stages.
// A stalled output holds the whole pipeline, so the input stalls in the same
// cycle. Configuration registers sit at byte addresses 0, 4 and 8.
module joystick_polar_direction #(
  parameter int unsigned CORDIC_STEPS = jpd_pkg::CORDIC_STEPS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  jpd_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output jpd_pkg::out_t  out_data_o,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  localparam int unsigned AB = jpd_pkg::ADC_BITS;

  jpd_pkg::cfg_t cfg;
  logic          en;
  logic          out_valid_q;
  jpd_pkg::out_t out_q;

  jpd_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o (cfg)
  );

  // The pipeline moves when the output register is free or being taken.
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // Stage A: remove centre codes, scale to Q2.14, north positive.
  logic signed [AB:0]  dx, dy;
  logic signed [15:0]  xa_q, ya_q;
  logic                va_q;

  assign dx = $signed({1'b0, in_data_i.horiz_sample}) - $signed({1'b0, cfg.x_centre});
  assign dy = $signed({1'b0, cfg.y_centre}) - $signed({1'b0, in_data_i.vert_sample});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en) begin
      va_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xa_q <= jpd_pkg::scale_axis(dx);
      ya_q <= jpd_pkg::scale_axis(dy);
    end
  end

  // Stage B: 1 - other^2/2 for each axis's circle factor.
  logic signed [31:0] sqx, sqy;
  logic [14:0]        tx_q, ty_q;
  logic signed [15:0] xb_q, yb_q;
  logic               vb_q;

  assign sqx = xa_q * xa_q;
  assign sqy = ya_q * ya_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tx_q <= 15'(jpd_pkg::Q14_ONE) - sqx[29:15];
      ty_q <= 15'(jpd_pkg::Q14_ONE) - sqy[29:15];
      xb_q <= xa_q;
      yb_q <= ya_q;
    end
  end

  // Circle factors sqrt(t << 14), one root pipeline per axis.
  logic        vr_x, vr_y;
  logic [14:0] root_y, root_x;
  logic [15:0] xr, yr;

  jpd_isqrt #(.IN_W(30), .SIDE_W(16)) u_root_y (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vb_q),
    .radicand_i({1'b0, ty_q, 14'd0}), .side_i(xb_q),
    .valid_o(vr_x), .root_o(root_y), .side_o(xr)
  );

  jpd_isqrt #(.IN_W(30), .SIDE_W(16)) u_root_x (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vb_q),
    .radicand_i({1'b0, tx_q, 14'd0}), .side_i(yb_q),
    .valid_o(vr_y), .root_o(root_x), .side_o(yr)
  );

  // Stage C: mapped coordinates, truncated toward zero.
  logic [15:0]        ax, ay;
  logic [29:0]        px, py;
  logic signed [15:0] mx_q, my_q;
  logic               vc_q;

  assign ax = xr[15] ? -xr : xr;
  assign ay = yr[15] ? -yr : yr;
  assign px = 30'(ax[14:0]) * 30'(root_y);
  assign py = 30'(ay[14:0]) * 30'(root_x);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (en) begin
      vc_q <= vr_x && vr_y;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mx_q <= xr[15] ? -$signed(px[29:14]) : $signed(px[29:14]);
      my_q <= yr[15] ? -$signed(py[29:14]) : $signed(py[29:14]);
    end
  end

  // Stage D: squares of the mapped coordinates.
  logic signed [31:0] smx, smy;
  logic [28:0]        smx_q, smy_q;
  logic signed [15:0] md_x_q, md_y_q;
  logic               vd_q;

  assign smx = mx_q * mx_q;
  assign smy = my_q * my_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (en) begin
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      smx_q  <= smx[28:0];
      smy_q  <= smy[28:0];
      md_x_q <= mx_q;
      md_y_q <= my_q;
    end
  end

  // Radius of the mapped point.
  logic        vm;
  logic [14:0] mag_raw;
  logic [31:0] mxy;

  jpd_isqrt #(.IN_W(30), .SIDE_W(32)) u_radius (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vd_q),
    .radicand_i(30'(smx_q) + 30'(smy_q)), .side_i({md_x_q, md_y_q}),
    .valid_o(vm), .root_o(mag_raw), .side_o(mxy)
  );

  // Heading of the mapped point; the clamped magnitude rides alongside.
  logic [14:0] mag_sat;
  logic        vh;
  logic [14:0] heading;
  logic [46:0] hside;

  assign mag_sat = (mag_raw > 15'(jpd_pkg::Q14_ONE)) ? 15'(jpd_pkg::Q14_ONE) : mag_raw;

  jpd_cordic #(.STEPS(CORDIC_STEPS), .SIDE_W(47)) u_cordic (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vm),
    .east_i($signed(mxy[31:16])), .north_i($signed(mxy[15:0])),
    .side_i({mag_sat, mxy}),
    .valid_o(vh), .heading_o(heading), .side_o(hside)
  );

  // Output stage: dead zone and compass sector.
  logic [3:0]    k;
  logic          centred;
  jpd_pkg::out_t res;

  always_comb begin
    k = '0;
    for (int j = 0; j < 8; j++) begin
      k = k + 4'(heading >= jpd_pkg::SECTOR_EDGE[j]);
    end
    centred           = hside[46:32] < cfg.dead_zone;
    res.mapped_x      = $signed(hside[31:16]);
    res.mapped_y      = $signed(hside[15:0]);
    res.magnitude     = centred ? '0 : hside[46:32];
    res.heading       = centred ? '0 : heading;
    res.heading_valid = !centred;
    if (centred) begin
      res.direction = jpd_pkg::DIR_CENTRE;
    end else if (k == 4'd0 || k == 4'd8) begin
      res.direction = jpd_pkg::DIR_N;
    end else begin
      res.direction = k + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vh;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A centred result carries no magnitude, heading or direction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.heading_valid |->
      out_q.magnitude == '0 && out_q.heading == '0 &&
      out_q.direction == jpd_pkg::DIR_CENTRE)
    else $error("centred result with nonzero polar fields");

  // A valid heading lies within one turn and names a compass direction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.heading_valid |->
      out_q.heading < 15'(jpd_pkg::FULL_TURN_64) &&
      out_q.direction != jpd_pkg::DIR_CENTRE && out_q.direction <= 4'd8)
    else $error("heading or direction out of range");

  // Magnitude never exceeds unity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.magnitude <= 15'(jpd_pkg::Q14_ONE))
    else $error("magnitude above unity");

endmodule

FILE: design/jpd_regs.sv
// ----------------------------------------------------------------------------
// jpd_regs: configuration registers
// APB-style slave holding the two centre codes and the dead zone.
// ----------------------------------------------------------------------------
module jpd_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output jpd_pkg::cfg_t      cfg_o
);

  jpd_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register write decode; bits above each register's width are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[3:2])
        jpd_pkg::REG_X_CENTRE:  cfg_d.x_centre  = pwdata[jpd_pkg::ADC_BITS-1:0];
        jpd_pkg::REG_Y_CENTRE:  cfg_d.y_centre  = pwdata[jpd_pkg::ADC_BITS-1:0];
        jpd_pkg::REG_DEAD_ZONE: cfg_d.dead_zone = pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_centre  <= jpd_pkg::X_CENTRE_RST;
      cfg_q.y_centre  <= jpd_pkg::Y_CENTRE_RST;
      cfg_q.dead_zone <= jpd_pkg::DEAD_ZONE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read-back mux.
  always_comb begin
    unique case (paddr[3:2])
      jpd_pkg::REG_X_CENTRE:  prdata = 32'(cfg_q.x_centre);
      jpd_pkg::REG_Y_CENTRE:  prdata = 32'(cfg_q.y_centre);
      jpd_pkg::REG_DEAD_ZONE: prdata = 32'(cfg_q.dead_zone);
      default:                prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/jpd_isqrt.sv
// ----------------------------------------------------------------------------
// jpd_isqrt: pipelined integer square root
// Digit-by-digit restoring root, one result bit per register stage, with a
// sideband word that travels alongside. Result is the floor of the root.
// ----------------------------------------------------------------------------
module jpd_isqrt #(
  parameter int unsigned IN_W   = 30,
  parameter int unsigned SIDE_W = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [IN_W-1:0]       radicand_i,
  input  logic [SIDE_W-1:0]     side_i,
  output logic                  valid_o,
  output logic [IN_W/2-1:0]     root_o,
  output logic [SIDE_W-1:0]     side_o
);

  localparam int unsigned OUT_W = IN_W / 2;
  localparam int unsigned RW    = OUT_W + 3;

  logic [RW-1:0]     rem_q  [OUT_W+1];
  logic [OUT_W-1:0]  root_q [OUT_W+1];
  logic [IN_W-1:0]   rad_q  [OUT_W+1];
  logic [SIDE_W-1:0] side_q [OUT_W+1];
  logic              vld_q  [OUT_W+1];

  // Stage inputs.
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign rad_q[0]  = radicand_i;
  assign side_q[0] = side_i;
  assign vld_q[0]  = valid_i;

  for (genvar s = 0; s < OUT_W; s++) begin : g_stage
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;
    logic          ge;

    // Bring down the next two radicand bits and try the next root bit.
    assign rem_sh = {rem_q[s][RW-3:0], rad_q[s][IN_W-1-2*s -: 2]};
    assign trial  = RW'({root_q[s], 2'b01});
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= ge ? rem_sh - trial : rem_sh;
        root_q[s+1] <= {root_q[s][OUT_W-2:0], ge};
        rad_q[s+1]  <= rad_q[s];
        side_q[s+1] <= side_q[s];
      end
    end
  end

  assign valid_o = vld_q[OUT_W];
  assign root_o  = root_q[OUT_W];
  assign side_o  = side_q[OUT_W];

endmodule

FILE: design/jpd_cordic.sv
// ----------------------------------------------------------------------------
// jpd_cordic: pipelined compass heading
// CORDIC vectoring of (north, east) with one micro-rotation per stage, then
// wrap and rounding to a heading in 1/64 degree, 0 at north, clockwise.
// ----------------------------------------------------------------------------
module jpd_cordic #(
  parameter int unsigned STEPS  = jpd_pkg::CORDIC_STEPS_DEF,
  parameter int unsigned SIDE_W = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic signed [15:0]  east_i,
  input  logic signed [15:0]  north_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                valid_o,
  output logic [14:0]         heading_o,
  output logic [SIDE_W-1:0]   side_o
);

  localparam int unsigned CW = jpd_pkg::CORDIC_CW;
  localparam int unsigned ZW = jpd_pkg::CORDIC_ZW;

  logic signed [CW-1:0] cx_q   [STEPS+1];
  logic signed [CW-1:0] cy_q   [STEPS+1];
  logic signed [ZW-1:0] z_q    [STEPS+1];
  logic                 zero_q [STEPS+1];
  logic [SIDE_W-1:0]    side_q [STEPS+1];
  logic                 vld_q  [STEPS+1];

  logic signed [CW-1:0] cx0, cy0;
  logic                 flip;

  // Prerotation: bring the vector into the right half plane.
  assign cx0  = CW'(north_i) <<< 8;
  assign cy0  = CW'(east_i) <<< 8;
  assign flip = cx0 < 0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx_q[0]   <= flip ? -cx0 : cx0;
      cy_q[0]   <= flip ? -cy0 : cy0;
      z_q[0]    <= flip ? ZW'(jpd_pkg::HALF_TURN_FINE) : '0;
      zero_q[0] <= (east_i == '0) && (north_i == '0);
      side_q[0] <= side_i;
    end
  end

  // Micro-rotations, one per stage, driving y toward zero.
  for (genvar i = 0; i < STEPS; i++) begin : g_rot
    logic signed [ZW-1:0] ang;
    logic                 pos;

    assign ang = ZW'(jpd_pkg::ATAN_FINE[i]);
    assign pos = cy_q[i] > 0;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cx_q[i+1]   <= pos ? cx_q[i] + (cy_q[i] >>> i) : cx_q[i] - (cy_q[i] >>> i);
        cy_q[i+1]   <= pos ? cy_q[i] - (cx_q[i] >>> i) : cy_q[i] + (cx_q[i] >>> i);
        z_q[i+1]    <= pos ? z_q[i] + ang : z_q[i] - ang;
        zero_q[i+1] <= zero_q[i];
        side_q[i+1] <= side_q[i];
      end
    end
  end

  // Wrap to a positive angle and round half up to 1/64 degree.
  logic signed [ZW-1:0] z_pos, z_rnd;
  logic [16:0]          h_raw;
  logic [14:0]          h_d, h_q;
  logic [SIDE_W-1:0]    side_out_q;
  logic                 vld_out_q;

  always_comb begin
    z_pos = (z_q[STEPS] < 0) ? z_q[STEPS] + ZW'(jpd_pkg::FULL_TURN_FINE) : z_q[STEPS];
    z_rnd = z_pos + ZW'(128);
    h_raw = z_rnd[24:8];
    if (h_raw >= 17'(jpd_pkg::FULL_TURN_64)) begin
      h_raw = h_raw - 17'(jpd_pkg::FULL_TURN_64);
    end
    h_d = zero_q[STEPS] ? '0 : h_raw[14:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else if (en_i) begin
      vld_out_q <= vld_q[STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h_q        <= h_d;
      side_out_q <= side_q[STEPS];
    end
  end

  assign valid_o   = vld_out_q;
  assign heading_o = h_q;
  assign side_o    = side_out_q;

endmodule
